// ----- design/double_ended_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, quiet during reset
`define DQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Queue geometry
  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Word returned by a pop from an empty queue
  localparam logic signed [WORD_W-1:0] POP_EMPTY_WORD = -1;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_POP_FRONT  = 2'd1,
    REQ_PUSH_BACK  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_type_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell; at most one flag is set,
  // and only for a request that succeeds
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
  } cell_ctl_t;

endpackage

// ----- design/dq_cell.sv -----
// ----------------------------------------------------------------------------
// dq_cell
// One queue slot: holds a word and a valid bit, trades with its neighbors.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dq_pkg::cell_ctl_t                 ctl,
  input  logic signed [dq_pkg::WORD_W-1:0]  push_word,
  input  logic signed [dq_pkg::WORD_W-1:0]  left_word,
  input  logic                              left_valid,
  input  logic signed [dq_pkg::WORD_W-1:0]  right_word,
  input  logic                              right_valid,
  output logic signed [dq_pkg::WORD_W-1:0]  word,
  output logic                              valid,
  output logic                              is_last
);
  import dq_pkg::*;

  logic signed [WORD_W-1:0] word_r, word_nxt;
  logic                     valid_r, valid_nxt;

  // Next slot contents: shift toward the back, toward the front, fill the
  // first empty slot, or drop the last occupied one
  always_comb begin
    word_nxt  = word_r;
    valid_nxt = valid_r;
    priority if (ctl.push_front) begin
      word_nxt  = left_word;
      valid_nxt = left_valid;
    end else if (ctl.pop_front) begin
      word_nxt  = right_word;
      valid_nxt = right_valid;
    end else if (ctl.push_back && !valid_r && left_valid) begin
      word_nxt  = push_word;
      valid_nxt = 1'b1;
    end else if (ctl.pop_back && valid_r && !right_valid) begin
      valid_nxt = 1'b0;
    end
  end

  // Occupancy bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign valid   = valid_r;
  assign is_last = valid_r && !right_valid;

endmodule

// ----- design/dq_cell_row.sv -----
// ----------------------------------------------------------------------------
// dq_cell_row
// Chain of DEPTH cells; position 0 is the front of the queue.
// ----------------------------------------------------------------------------
module dq_cell_row (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dq_pkg::cell_ctl_t                 ctl,
  input  logic signed [dq_pkg::WORD_W-1:0]  push_word,
  output logic signed [dq_pkg::WORD_W-1:0]  front_word,
  output logic signed [dq_pkg::WORD_W-1:0]  back_word
);
  import dq_pkg::*;

  logic signed [WORD_W-1:0] cell_word  [DEPTH];
  logic                     cell_valid [DEPTH];
  logic                     cell_last  [DEPTH];

  // Neighbor links; the front end sees the incoming word as valid,
  // the back end sees an empty slot
  logic signed [WORD_W-1:0] left_word  [DEPTH];
  logic                     left_valid [DEPTH];
  logic signed [WORD_W-1:0] right_word  [DEPTH];
  logic                     right_valid [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_front
      assign left_word[i]  = push_word;
      assign left_valid[i] = 1'b1;
    end else begin : g_inner_l
      assign left_word[i]  = cell_word[i-1];
      assign left_valid[i] = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_back
      assign right_word[i]  = '0;
      assign right_valid[i] = 1'b0;
    end else begin : g_inner_r
      assign right_word[i]  = cell_word[i+1];
      assign right_valid[i] = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .push_word   (push_word),
      .left_word   (left_word[i]),
      .left_valid  (left_valid[i]),
      .right_word  (right_word[i]),
      .right_valid (right_valid[i]),
      .word        (cell_word[i]),
      .valid       (cell_valid[i]),
      .is_last     (cell_last[i])
    );
  end

  assign front_word = cell_word[0];

  // Back word: at most one cell flags itself as last, so an AND-OR select
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | (cell_word[i] & {WORD_W{cell_last[i]}});
    end
  end

endmodule

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words built as a shifting row of cells.
// ----------------------------------------------------------------------------
// Each request (push front, pop front, push back, pop back) gives one result
// registered on its transfer, and a new request is taken every cycle while
// the result side keeps up; a held result stalls the input only while
// out_stall is high. Up to DEPTH words are kept in a row of cells: front
// operations shift the whole row by one slot, a push at the back fills the
// slot just past the last occupied one and a pop at the back empties the last
// occupied one. A pop from an empty queue returns -1 with the empty status; a
// push into a full queue is dropped with the full status. occupancy is the
// entry count after the request.
module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic signed [dq_pkg::WORD_W-1:0]  in_push_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dq_pkg::WORD_W-1:0]  out_pop_word,
  output logic [1:0]                        out_status,
  output logic [dq_pkg::CNT_W-1:0]          out_occupancy
);
  import dq_pkg::*;

  req_type_t                req;
  logic                     in_xfer;
  logic                     is_empty, is_full;
  cell_ctl_t                ctl;
  logic signed [WORD_W-1:0] front_word, back_word;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_word_r, res_word;
  status_t                  out_status_r, res_status;
  logic [CNT_W-1:0]         out_count_r;

  // Handshake: take a request whenever the output register is free or drains
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign req      = req_type_t'(in_req_type);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(DEPTH));

  // Decode the request into a cell command and a result
  always_comb begin
    ctl        = '0;
    res_word   = '0;
    res_status = ST_OK;
    count_nxt  = count_r;
    unique case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (is_full) begin
          res_status = ST_FULL;
        end else begin
          ctl.push_front = in_xfer && (req == REQ_PUSH_FRONT);
          ctl.push_back  = in_xfer && (req == REQ_PUSH_BACK);
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (is_empty) begin
          res_word   = POP_EMPTY_WORD;
          res_status = ST_EMPTY;
        end else begin
          ctl.pop_front = in_xfer && (req == REQ_POP_FRONT);
          ctl.pop_back  = in_xfer && (req == REQ_POP_BACK);
          res_word      = (req == REQ_POP_FRONT) ? front_word : back_word;
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  dq_cell_row u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .push_word  (in_push_word),
    .front_word (front_word),
    .back_word  (back_word)
  );

  // Output register valid: set on a transfer, cleared once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on each transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_word_r   <= res_word;
      out_status_r <= res_status;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_word  = out_word_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_count_r;

endmodule

// ----- design/dq_checker.sv -----
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module dq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [dq_pkg::WORD_W-1:0]  out_pop_word,
  input logic [1:0]                        out_status,
  input logic [dq_pkg::CNT_W-1:0]          out_occupancy
);
  import dq_pkg::*;

  // A stalled result stays put
  `DQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pop_word) && $stable(out_status) && $stable(out_occupancy), "result changed while stalled")

  // Empty error carries -1 and an empty queue
  `DQ_ASSERT_SAME(a_empty_result, clk, rst_n, out_valid && (out_status == ST_EMPTY), (out_pop_word == POP_EMPTY_WORD) && (out_occupancy == '0), "bad empty-pop result")

  // Full error carries 0 and a full queue
  `DQ_ASSERT_SAME(a_full_result, clk, rst_n, out_valid && (out_status == ST_FULL), (out_pop_word == '0) && (out_occupancy == CNT_W'(DEPTH)), "bad full-push result")

  // Count stays within the queue depth and status is a defined code
  `DQ_ASSERT_SAME(a_bounds, clk, rst_n, out_valid, (out_occupancy <= CNT_W'(DEPTH)) && (out_status != 2'd3), "occupancy or status out of range")

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

// ----- tb/double_ended_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded deque: a queued request driver, a
// transaction-level deque predictor and a result monitor that compares every
// transfer with the predicted pop word, status and occupancy.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 138;

  typedef struct {
    req_type_t               req;
    logic signed [WORD_W-1:0] word;
  } deq_request_t;

  typedef struct {
    logic signed [WORD_W-1:0] pop_word;
    status_t                  status;
    logic [CNT_W-1:0]         occupancy;
  } deq_result_t;

  // DUT ports; the driven inputs are known from time zero
  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_req_type   = '0;
  logic signed [WORD_W-1:0] in_push_word  = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic signed [WORD_W-1:0] out_pop_word;
  logic [1:0]               out_status;
  logic [CNT_W-1:0]         out_occupancy;

  // Stimulus and expectations
  deq_request_t pending_requests[$];
  deq_result_t  expected_results[$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;

  // Predictor state
  logic signed [WORD_W-1:0] model_ring[DEPTH];
  int model_front = 0;
  int model_back  = 0;
  int model_count = 0;

  // Run statistics
  int n_push_ok = 0;
  int n_pop_ok  = 0;
  int n_empty   = 0;
  int n_full    = 0;
  int n_checked = 0;
  int n_errors  = 0;

  double_ended_queue uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_push_word  (in_push_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pop_word  (out_pop_word),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the deque model and return its result
  function automatic deq_result_t deq_apply(input req_type_t req,
                                            input logic signed [WORD_W-1:0] word);
    deq_result_t r;
    r.pop_word = '0;
    r.status   = ST_OK;
    if (req == REQ_POP_FRONT || req == REQ_POP_BACK) begin
      if (model_count == 0) begin
        r.pop_word = POP_EMPTY_WORD;
        r.status   = ST_EMPTY;
        n_empty++;
      end else if (req == REQ_POP_FRONT) begin
        r.pop_word  = model_ring[model_front];
        model_front = (model_front + 1) % DEPTH;
        model_count--;
        n_pop_ok++;
      end else begin
        model_back = (model_back + DEPTH - 1) % DEPTH;
        r.pop_word = model_ring[model_back];
        model_count--;
        n_pop_ok++;
      end
    end else begin
      if (model_count >= DEPTH) begin
        r.status = ST_FULL;
        n_full++;
      end else if (req == REQ_PUSH_FRONT) begin
        model_front             = (model_front + DEPTH - 1) % DEPTH;
        model_ring[model_front] = word;
        model_count++;
        n_push_ok++;
      end else begin
        model_ring[model_back] = word;
        model_back             = (model_back + 1) % DEPTH;
        model_count++;
        n_push_ok++;
      end
    end
    r.occupancy = model_count[CNT_W-1:0];
    return r;
  endfunction

  // Word mix: extremes, small values and full-range random bits
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return '0;
      4:       return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(input req_type_t req, input logic signed [WORD_W-1:0] word);
    deq_request_t item;
    item.req  = req;
    item.word = word;
    pending_requests.push_back(item);
  endtask

  // Random requests in bursts that lean toward pushes or pops, so the
  // occupancy sweeps between empty and full; balanced bursts act as noise
  task automatic add_random_requests(input int count);
    int push_pct;
    int left;
    left = 0;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(12, 40);
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      left--;
      if ($urandom_range(99) < push_pct)
        add_request($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_word());
      else
        add_request($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT, pick_word());
    end
  endtask

  // Wait until every request is sent and every result is back
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Request driver: hold a request until its transfer, then offer the next
  always @(posedge clk) begin : drive_requests
    deq_result_t r;
    logic        busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        r = deq_apply(req_type_t'(in_req_type), in_push_word);
        expected_results.push_back(r);
        void'(pending_requests.pop_front());
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          in_req_type  <= pending_requests[0].req;
          in_push_word <= pending_requests[0].word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result-side stall: random, or a long hold-off when requested
  always @(posedge clk) begin : drive_stall
    int hold_left;
    int hold_seen;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_seen = hold_token;
    end else if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    deq_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result pop_word %0d status %0d occupancy %0d",
                 $time, out_pop_word, out_status, out_occupancy);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (out_pop_word !== want.pop_word) begin
          $display("%0t: pop_word expected %0d actual %0d", $time, want.pop_word, out_pop_word);
          n_errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          n_errors++;
        end
        if (out_occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d",
                   $time, want.occupancy, out_occupancy);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty pops, extreme words, fill to full, full drops
    add_request(REQ_POP_FRONT, 32'sh1234_5678);
    add_request(REQ_POP_BACK, '0);
    add_request(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
    add_request(REQ_PUSH_BACK, 32'sh8000_0000);
    add_request(REQ_POP_FRONT, '0);
    add_request(REQ_POP_BACK, '0);
    for (int i = 0; i < DEPTH; i++)
      add_request((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                  (i == 0) ? -32'sd1 : (i == 1) ? 32'sd0 : $urandom);
    add_request(REQ_PUSH_FRONT, 32'sh5555_AAAA);
    add_request(REQ_PUSH_BACK, 32'shAAAA_5555);
    wait_drained();

    // No idling, opening with a long result hold-off to back up the input
    hold_token++;
    add_random_requests(PHASE_ITEMS);
    wait_drained();

    // Sender idles
    send_idle_pct = 48;
    add_random_requests(PHASE_ITEMS);
    wait_drained();

    // Receiver stalls
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    add_random_requests(PHASE_ITEMS);
    wait_drained();

    // Both sides idle
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    add_random_requests(PHASE_ITEMS);
    wait_drained();

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      n_errors++;
    end
    $display("Covered %0d results: %0d pushes stored, %0d pops served,",
             n_checked, n_push_ok, n_pop_ok);
    $display("%0d pops on empty, %0d pushes dropped when full, %0d mismatches",
             n_empty, n_full, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/dq_pkg.sv
design/dq_cell.sv
design/dq_cell_row.sv
design/double_ended_queue.sv
design/dq_checker.sv
tb/double_ended_queue_tb.sv
